// ===== hdl/rcfd_pkg.sv =====
// Shared types, constants and helper functions for the calendar register decoder.
package rcfd_pkg;

  localparam int TimeW   = 23;
  localparam int DateW   = 24;
  localparam int MinPerHr = 60;
  localparam int PmHours  = 12;
  localparam int WeekLen  = 7;
  // floor(x / 7) == (x * 293) >> 11 for every x below 512
  localparam int Div7Mul   = 293;
  localparam int Div7Shift = 11;
  localparam logic [2:0] SundayCode = 3'd7;

  typedef struct packed {
    logic [TimeW-1:0] time_word;
    logic [DateW-1:0] date_word;
  } in_t;

  typedef struct packed {
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [5:0]  day;
    logic [4:0]  month;
    logic [7:0]  year;
    logic [2:0]  weekday;
    logic [12:0] minute_of_day;
    logic [8:0]  day_of_year;
    logic [6:0]  week_of_year;
  } out_t;

  // Plain calendar fields handed from the field decoder to the derived-value logic.
  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic [2:0] weekday;
  } fld_t;

  // Weight tens by ten without checking digits; nibbles 10..15 pass as given.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'(v[7:4]);
    lo = 8'(v[3:0]);
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Days before the month; months outside 1..12 get 0.
  function automatic logic [8:0] days_before(input logic [4:0] month);
    logic [8:0] d;
    unique case (month)
      5'd1:    d = 9'd0;
      5'd2:    d = 9'd31;
      5'd3:    d = 9'd59;
      5'd4:    d = 9'd90;
      5'd5:    d = 9'd120;
      5'd6:    d = 9'd151;
      5'd7:    d = 9'd181;
      5'd8:    d = 9'd212;
      5'd9:    d = 9'd243;
      5'd10:   d = 9'd273;
      5'd11:   d = 9'd304;
      5'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/rcfd_field_decode.sv =====
// BCD field extraction and conversion of the time and date words.
module rcfd_field_decode (
  input  rcfd_pkg::in_t  in_word,
  output rcfd_pkg::fld_t fld
);

  logic [22:0] tw;
  logic [23:0] dw;
  logic [5:0]  hour_raw;

  assign tw = in_word.time_word;
  assign dw = in_word.date_word;

  assign hour_raw = 6'(rcfd_pkg::bcd_to_bin({2'b00, tw[21:16]}));

  always_comb begin
    // add the afternoon offset when PM is flagged
    fld.hour    = tw[22] ? hour_raw + 6'(rcfd_pkg::PmHours) : hour_raw;
    fld.minute  = 7'(rcfd_pkg::bcd_to_bin({1'b0, tw[14:8]}));
    fld.second  = 7'(rcfd_pkg::bcd_to_bin({1'b0, tw[6:0]}));
    fld.day     = 6'(rcfd_pkg::bcd_to_bin({2'b00, dw[5:0]}));
    fld.month   = 5'(rcfd_pkg::bcd_to_bin({3'b000, dw[12:8]}));
    fld.year    = rcfd_pkg::bcd_to_bin(dw[23:16]);
    // Sunday folds to 0
    fld.weekday = (dw[15:13] == rcfd_pkg::SundayCode) ? 3'd0 : dw[15:13];
  end

endmodule

// ===== hdl/rcfd_derive.sv =====
// Minute of day, day of year and week of year from decoded calendar fields.
module rcfd_derive (
  input  rcfd_pkg::fld_t fld,
  output rcfd_pkg::out_t res
);

  logic        leap_add;
  logic [8:0]  doy;
  logic [9:0]  week_num;
  logic [17:0] week_prod;

  assign leap_add = (fld.year[1:0] == 2'b00) && (fld.month > 5'd2);
  assign doy      = rcfd_pkg::days_before(fld.month) + 9'(fld.day) + 9'(leap_add);

  // divide by seven through a reciprocal multiply; exact for the numerator range
  assign week_num  = 10'(doy) + 10'(rcfd_pkg::WeekLen) - 10'(fld.weekday);
  assign week_prod = 18'(week_num) * 18'(rcfd_pkg::Div7Mul);

  always_comb begin
    res.hour          = fld.hour;
    res.minute        = fld.minute;
    res.second        = fld.second;
    res.day           = fld.day;
    res.month         = fld.month;
    res.year          = fld.year;
    res.weekday       = fld.weekday;
    res.minute_of_day = 13'(fld.hour) * 13'(rcfd_pkg::MinPerHr) + 13'(fld.minute);
    res.day_of_year   = doy;
    res.week_of_year  = 7'(week_prod >> rcfd_pkg::Div7Shift) + 7'd1;
  end

endmodule

// ===== hdl/rtc_calendar_feature_decode.sv =====
// Top level: input register, calendar decode logic and result register.
// Path: an accepted beat passes the input register, then the result register, and shows
//   on out_data with out_valid high; it is taken at the edge that ends that cycle.
// Throughput: one beat per cycle while busy is low; set by the two register stages, nothing iterates.
// Reset: synchronous, active low; clears the valid flags and holds busy high
//   until the first clock edge after rst_n rises. The receiver cannot stall.
module rtc_calendar_feature_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rcfd_pkg::in_t  in_data,
  output logic           out_valid,
  output rcfd_pkg::out_t out_data
);

  logic           busy_r;
  logic           in_vld_r;
  rcfd_pkg::in_t  in_data_r;
  logic           out_vld_r;
  rcfd_pkg::out_t out_data_r;

  rcfd_pkg::fld_t fld;
  rcfd_pkg::out_t res_nxt;
  logic           accept;

  // Take a beat whenever start is high and we are out of reset; no backpressure
  // exists downstream, so the pipe never has to stop.
  assign accept = start && !busy_r;

  // Hold busy only while reset is applied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Input stage: capture the register pair of an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
  end

  // Unpack BCD fields, then derive the calendar counts.
  rcfd_field_decode u_field_decode (
    .in_word (in_data_r),
    .fld     (fld)
  );

  rcfd_derive u_derive (
    .fld (fld),
    .res (res_nxt)
  );

  // Result stage: strobe each result for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/rcfd_checker.sv =====
// Port-level checker for the calendar register decoder and its bind.
module rcfd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input rcfd_pkg::in_t  in_data,
  input logic           out_valid,
  input rcfd_pkg::out_t out_data
);

  // Every accepted beat comes out after the input and result registers.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  // No result without an accepted beat that passed the input and result registers.
  a_no_invent : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  a_weekday : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.weekday != rcfd_pkg::SundayCode))
    else $error("Sunday code not folded");

  a_mod : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.minute_of_day ==
                   13'(out_data.hour) * 13'd60 + 13'(out_data.minute)))
    else $error("minute of day inconsistent with hour and minute");

  a_week : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.week_of_year != 7'd0))
    else $error("week of year is zero");

endmodule

bind rtc_calendar_feature_decode rcfd_checker u_rcfd_checker (.*);

// ===== tb/rtc_calendar_feature_decode_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the calendar register decoder: directed, valid-date and raw-word beats.
module rtc_calendar_feature_decode_test;

  localparam int ClkHalf    = 10;
  localparam int ResetLen   = 10;
  localparam int CycleLimit = 100000;
  localparam int DrainWait  = 8;
  localparam int ReportMax  = 10;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  rcfd_pkg::in_t  in_data;
  logic           out_valid;
  rcfd_pkg::out_t out_data;

  // Decodes still owed by the block, oldest first.
  rcfd_pkg::out_t pending_decodes[$];
  int   mismatch_count;
  int   cycle_count;
  // Chance, in percent, that the sender holds back before a beat; drawn anew after each wait.
  int   idle_pct;

  rtc_calendar_feature_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #ClkHalf;
    clk = 1'b1;
    #ClkHalf;
  end

  // Weight the tens nibble by ten; non-decimal nibbles are taken at face value.
  function automatic int bcd_value(input logic [7:0] v);
    return int'(v[7:4]) * 10 + int'(v[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Days elapsed before the first of a month; anything outside 1..12 counts as 0.
  function automatic int month_offset(input int mo);
    case (mo)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  // Work out the full result for one time/date word pair.
  function automatic rcfd_pkg::out_t decode_calendar(input rcfd_pkg::in_t beat);
    rcfd_pkg::out_t r;
    logic [22:0] tw;
    logic [23:0] dw;
    int          hr;
    int          mn;
    int          mo;
    int          yr;
    int          wd;
    int          dy;
    int          doy;
    tw = beat.time_word;
    dw = beat.date_word;
    hr = bcd_value({2'b00, tw[21:16]}) + (tw[22] ? 12 : 0);
    mn = bcd_value({1'b0, tw[14:8]});
    dy = bcd_value({2'b00, dw[5:0]});
    mo = bcd_value({3'b000, dw[12:8]});
    yr = bcd_value(dw[23:16]);
    wd = int'(dw[15:13]);
    if (wd == 7) wd = 0;
    doy = month_offset(mo) + dy;
    // Leap day lands on every month past February, out-of-range months too.
    if (yr % 4 == 0 && mo > 2) doy = doy + 1;
    r.hour          = 6'(hr);
    r.minute        = 7'(mn);
    r.second        = 7'(bcd_value({1'b0, tw[6:0]}));
    r.day           = 6'(dy);
    r.month         = 5'(mo);
    r.year          = 8'(yr);
    r.weekday       = 3'(wd);
    r.minute_of_day = 13'(hr * 60 + mn);
    r.day_of_year   = 9'(doy);
    r.week_of_year  = 7'((doy + 7 - wd) / 7 + 1);
    return r;
  endfunction

  function automatic rcfd_pkg::in_t pack_words(input logic pm, input int hr, input int mn,
                                               input int sc, input int yr, input int wd,
                                               input int mo, input int dy);
    rcfd_pkg::in_t w;
    logic [7:0]    hr_b;
    logic [7:0]    mn_b;
    logic [7:0]    sc_b;
    logic [7:0]    mo_b;
    logic [7:0]    dy_b;
    hr_b = to_bcd(hr);
    mn_b = to_bcd(mn);
    sc_b = to_bcd(sc);
    mo_b = to_bcd(mo);
    dy_b = to_bcd(dy);
    w.time_word = {pm, hr_b[5:0], 1'b0, mn_b[6:0], 1'b0, sc_b[6:0]};
    w.date_word = {to_bcd(yr), 3'(wd), mo_b[4:0], 2'b00, dy_b[5:0]};
    return w;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(input rcfd_pkg::in_t beat);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= beat;
    // Hold start and the payload through busy; the beat goes at the first edge with busy low.
    do @(posedge clk); while (busy !== 1'b0);
    pending_decodes.push_back(decode_calendar(beat));
  endtask

  // Extremes, leap-year boundaries, odd months, non-decimal nibbles and every weekday code.
  task automatic test_directed;
    idle_pct = 0;
    send_beat('0);
    send_beat('1);
    send_beat(pack_words(1'b0, 0, 0, 0, 0, 1, 1, 1));
    send_beat(pack_words(1'b1, 11, 59, 59, 99, 6, 12, 31));
    send_beat(pack_words(1'b0, 23, 59, 59, 24, 2, 12, 31));
    send_beat(pack_words(1'b0, 12, 30, 0, 24, 4, 2, 29));
    send_beat(pack_words(1'b0, 8, 15, 30, 24, 5, 3, 1));
    send_beat(pack_words(1'b0, 8, 15, 30, 23, 5, 3, 1));
    send_beat(pack_words(1'b1, 1, 1, 1, 0, 3, 11, 30));
    send_beat(pack_words(1'b0, 9, 0, 0, 96, 1, 10, 1));
    // Month zero and months past twelve get no offset; a leap year still adds a day past twelve.
    send_beat(pack_words(1'b0, 0, 0, 0, 20, 7, 0, 15));
    send_beat(pack_words(1'b0, 0, 0, 0, 20, 7, 13, 15));
    send_beat(pack_words(1'b0, 0, 0, 0, 21, 7, 13, 15));
    send_beat('{time_word: 23'h7F7F7F, date_word: 24'hFF1F3F});
    send_beat('{time_word: 23'h3F7A7A, date_word: 24'hAA1A3A});
    // Walk the weekday field through all eight codes, including zero.
    for (int wd = 0; wd < 8; wd++) begin
      send_beat(pack_words(1'b0, 10, 20, 30, 48, wd, 6, 15));
    end
  endtask

  // Well-formed time and date registers with random content.
  task automatic test_calendar_dates(input int count);
    int hr;
    for (int i = 0; i < count; i++) begin
      hr = $urandom_range(23);
      send_beat(pack_words(hr < 12 ? 1'($urandom_range(1)) : 1'b0, hr,
                           $urandom_range(59), $urandom_range(59), $urandom_range(99),
                           $urandom_range(7, 1), $urandom_range(12, 1), $urandom_range(31, 1)));
    end
  endtask

  // Unconstrained words: garbage nibbles, stray spare bits, any month.
  task automatic test_raw_words(input int count);
    rcfd_pkg::in_t w;
    for (int i = 0; i < count; i++) begin
      w.time_word = 23'($urandom);
      w.date_word = 24'($urandom);
      send_beat(w);
    end
  endtask

  // Compare each result with the oldest owed decode, field by field.
  always @(posedge clk) begin
    rcfd_pkg::out_t want;
    string          diffs;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("%0t: result beat with nothing owed: %p", $realtime, out_data);
      end else begin
        want  = pending_decodes.pop_front();
        diffs = "";
        if (out_data.hour !== want.hour)
          diffs = {diffs, $sformatf(" hour exp %0d got %0d", want.hour, out_data.hour)};
        if (out_data.minute !== want.minute)
          diffs = {diffs, $sformatf(" minute exp %0d got %0d", want.minute, out_data.minute)};
        if (out_data.second !== want.second)
          diffs = {diffs, $sformatf(" second exp %0d got %0d", want.second, out_data.second)};
        if (out_data.day !== want.day)
          diffs = {diffs, $sformatf(" day exp %0d got %0d", want.day, out_data.day)};
        if (out_data.month !== want.month)
          diffs = {diffs, $sformatf(" month exp %0d got %0d", want.month, out_data.month)};
        if (out_data.year !== want.year)
          diffs = {diffs, $sformatf(" year exp %0d got %0d", want.year, out_data.year)};
        if (out_data.weekday !== want.weekday)
          diffs = {diffs, $sformatf(" weekday exp %0d got %0d", want.weekday, out_data.weekday)};
        if (out_data.minute_of_day !== want.minute_of_day)
          diffs = {diffs, $sformatf(" minute_of_day exp %0d got %0d",
                                    want.minute_of_day, out_data.minute_of_day)};
        if (out_data.day_of_year !== want.day_of_year)
          diffs = {diffs, $sformatf(" day_of_year exp %0d got %0d",
                                    want.day_of_year, out_data.day_of_year)};
        if (out_data.week_of_year !== want.week_of_year)
          diffs = {diffs, $sformatf(" week_of_year exp %0d got %0d",
                                    want.week_of_year, out_data.week_of_year)};
        if (diffs != "") begin
          mismatch_count++;
          if (mismatch_count <= ReportMax) $display("%0t: mismatch:%s", $realtime, diffs);
        end
      end
    end
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rtc_calendar_feature_decode_test: errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    idle_pct       = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (ResetLen) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    // The receiver takes every result, so only the sender idles: run back-to-back,
    // mostly idle, then lightly idle.
    idle_pct = 0;
    test_calendar_dates(170);
    test_raw_words(60);
    idle_pct = 68;
    test_calendar_dates(170);
    test_raw_words(60);
    idle_pct = 12;
    test_calendar_dates(170);
    test_raw_words(60);

    @(negedge clk);
    start <= 1'b0;
    // Drain what is owed, then keep watching the outputs for strays.
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rtc_calendar_feature_decode_test: clean");
    end else begin
      $display("rtc_calendar_feature_decode_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rcfd_pkg.sv
hdl/rcfd_field_decode.sv
hdl/rcfd_derive.sv
hdl/rtc_calendar_feature_decode.sv
hdl/rcfd_checker.sv
tb/rtc_calendar_feature_decode_test.sv
